// ===== rtl/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types and constants of the scalar kalman filter: register indexes,
// controller states and the command/status bundles between the two halves.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

  // error words are unsigned, ERR_W bits with FRAC_BITS fraction bits (q16.16 at the default)
  localparam int ERR_W = 32;

  // configuration register file
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_EST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_ERR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_ERR  = 2'd2;

  function automatic logic cfg_index_known(input logic [CFG_IDX_W-1:0] idx);
    return (idx == CFG_INIT_EST) || (idx == CFG_INIT_ERR) || (idx == CFG_MEAS_ERR);
  endfunction

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DIV_START,
    ST_DIV,
    ST_SET_GAIN,
    ST_IDLE,
    ST_MUL_EST,
    ST_UPD_EST,
    ST_MUL_ERR,
    ST_UPD_ERR,
    ST_FINISH
  } skf_state_t;

  typedef struct packed {
    logic load_state;
    logic capture;
    logic mul_est;
    logic upd_est;
    logic div_start;
    logic div_step;
    logic set_gain;
    logic mul_err;
    logic upd_err;
    logic out_load;
  } skf_cmd_t;

  typedef struct packed {
    logic div_last;
  } skf_status_t;

endpackage

`default_nettype wire

// ===== rtl/skf_sample_if.sv =====
// ----------------------------------------------------------------------------
// skf_sample_if
// Request channel carrying one raw converter sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface skf_sample_if #(
  parameter int SAMPLE_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

`default_nettype wire

// ===== rtl/skf_result_if.sv =====
// ----------------------------------------------------------------------------
// skf_result_if
// Request channel carrying one filter result: estimate, error and gain.
// ----------------------------------------------------------------------------
`default_nettype none

interface skf_result_if #(
  parameter int SAMPLE_BITS = 12,
  parameter int FRAC_BITS   = 16
) ();
  logic                             valid;
  logic                             ready;
  logic [SAMPLE_BITS+FRAC_BITS-1:0] estimate;
  logic [skf_pkg::ERR_W-1:0]        error_estimate;
  logic [FRAC_BITS:0]               gain;

  modport source (output valid, output estimate, output error_estimate, output gain,
                  input ready);
  modport sink   (input valid, input estimate, input error_estimate, input gain,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/skf_ctrl.sv =====
// ----------------------------------------------------------------------------
// skf_ctrl
// Sequencer of the filter: state reload, per-request step order, divider
// iteration and the output register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output skf_pkg::skf_cmd_t                 cmd,
  input  wire skf_pkg::skf_status_t         status
);

  skf_pkg::skf_state_t state;
  skf_pkg::skf_state_t state_next;
  logic                reload;
  logic                cfg_reload;

  // a write to a known register reloads all state
  assign cfg_reload = cfg_wr_en && skf_pkg::cfg_index_known(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skf_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // remembers whether the running division belongs to a reload
  always_ff @(posedge clk) begin
    if (rst) begin
      reload <= 1'b1;
    end else if (state == skf_pkg::ST_LOAD) begin
      reload <= 1'b1;
    end else if (state == skf_pkg::ST_SET_GAIN) begin
      reload <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      skf_pkg::ST_LOAD:      state_next = skf_pkg::ST_DIV_START;
      skf_pkg::ST_DIV_START: state_next = skf_pkg::ST_DIV;
      skf_pkg::ST_DIV: begin
        if (status.div_last) begin
          state_next = reload ? skf_pkg::ST_SET_GAIN : skf_pkg::ST_MUL_ERR;
        end
      end
      skf_pkg::ST_SET_GAIN:  state_next = skf_pkg::ST_IDLE;
      skf_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          state_next = skf_pkg::ST_MUL_EST;
        end
      end
      skf_pkg::ST_MUL_EST:   state_next = skf_pkg::ST_UPD_EST;
      skf_pkg::ST_UPD_EST:   state_next = skf_pkg::ST_DIV_START;
      skf_pkg::ST_MUL_ERR:   state_next = skf_pkg::ST_UPD_ERR;
      skf_pkg::ST_UPD_ERR:   state_next = skf_pkg::ST_FINISH;
      skf_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = skf_pkg::ST_IDLE;
        end
      end
      default:               state_next = skf_pkg::ST_LOAD;
    endcase
    if (cfg_reload) begin
      state_next = skf_pkg::ST_LOAD;
    end
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      skf_pkg::ST_LOAD:      cmd.load_state = 1'b1;
      skf_pkg::ST_DIV_START: cmd.div_start  = 1'b1;
      skf_pkg::ST_DIV:       cmd.div_step   = 1'b1;
      skf_pkg::ST_SET_GAIN:  cmd.set_gain   = 1'b1;
      skf_pkg::ST_IDLE: begin
        in_ready    = !cfg_reload;
        cmd.capture = in_valid && !cfg_reload;
      end
      skf_pkg::ST_MUL_EST:   cmd.mul_est    = 1'b1;
      skf_pkg::ST_UPD_EST:   cmd.upd_est    = 1'b1;
      skf_pkg::ST_MUL_ERR:   cmd.mul_err    = 1'b1;
      skf_pkg::ST_UPD_ERR:   cmd.upd_err    = 1'b1;
      skf_pkg::ST_FINISH:    cmd.out_load   = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/skf_datapath.sv =====
// ----------------------------------------------------------------------------
// skf_datapath
// Configuration registers, filter state, shared signed multiplier,
// restoring gain divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_datapath #(
  parameter int SAMPLE_BITS = 12,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [skf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [((SAMPLE_BITS+FRAC_BITS) > skf_pkg::ERR_W ?
                      (SAMPLE_BITS+FRAC_BITS) : skf_pkg::ERR_W)-1:0] cfg_data,
  input  wire logic [SAMPLE_BITS-1:0]                measurement,
  input  wire skf_pkg::skf_cmd_t                     cmd,
  output skf_pkg::skf_status_t                       status,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0]           res_estimate,
  output logic [skf_pkg::ERR_W-1:0]                  res_error,
  output logic [FRAC_BITS:0]                         res_gain
);

  localparam int EST_W   = SAMPLE_BITS + FRAC_BITS;
  localparam int ERR_W   = skf_pkg::ERR_W;
  localparam int GAIN_W  = FRAC_BITS + 1;
  localparam int INNOV_W = EST_W + 1;
  localparam int SUM_W   = ERR_W + 1;
  localparam int REM_W   = ERR_W + 2;
  localparam int MA_W    = GAIN_W + 1;
  localparam int MB_W    = (INNOV_W > SUM_W) ? INNOV_W : SUM_W;
  localparam int P_W     = MA_W + MB_W;
  localparam int CNT_W   = $clog2(FRAC_BITS + 1);

  localparam logic [EST_W-1:0]  INIT_EST_RST = EST_W'(64'd1024 << FRAC_BITS);
  localparam logic [ERR_W-1:0]  INIT_ERR_RST = ERR_W'(64'd2 << FRAC_BITS);
  localparam logic [GAIN_W-1:0] ONE_Q        = {1'b1, {FRAC_BITS{1'b0}}};

  // configuration
  logic [EST_W-1:0] init_est;
  logic [ERR_W-1:0] init_err;
  logic [ERR_W-1:0] meas_err;

  // filter state
  logic [EST_W-1:0]  est_value;
  logic [ERR_W-1:0]  est_error;
  logic [GAIN_W-1:0] gain_reg;

  // working registers
  logic signed [INNOV_W-1:0] innov;
  logic signed [P_W-1:0]     prod;
  logic [REM_W-1:0]          rem;
  logic [SUM_W-1:0]          dsum;
  logic [GAIN_W-1:0]         quot;
  logic [CNT_W-1:0]          cnt;

  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [P_W-1:0]     prod_sh;
  logic signed [EST_W+1:0]   est_sum;
  logic [EST_W-1:0]          est_sat;
  logic                      div_ge;
  logic [REM_W-1:0]          div_diff;
  logic [GAIN_W-1:0]         gain_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_est <= INIT_EST_RST;
      init_err <= INIT_ERR_RST;
      meas_err <= INIT_ERR_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        skf_pkg::CFG_INIT_EST: init_est <= cfg_data[EST_W-1:0];
        skf_pkg::CFG_INIT_ERR: init_err <= cfg_data[ERR_W-1:0];
        skf_pkg::CFG_MEAS_ERR: meas_err <= cfg_data[ERR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // shared multiplier operands: gain times innovation, or (1 - gain) times error
  always_comb begin
    if (cmd.mul_err) begin
      mul_a = $signed({1'b0, ONE_Q - gain_q});
      mul_b = $signed({{(MB_W-ERR_W){1'b0}}, est_error});
    end else begin
      mul_a = $signed({1'b0, gain_reg});
      mul_b = MB_W'(innov);
    end
  end

  // floor of the signed product, then clamp to the estimate range
  assign prod_sh = prod >>> FRAC_BITS;
  assign est_sum = $signed({2'b00, est_value}) + $signed(prod_sh[EST_W+1:0]);

  always_comb begin
    if (est_sum[EST_W+1]) begin
      est_sat = '0;
    end else if (est_sum[EST_W]) begin
      est_sat = '1;
    end else begin
      est_sat = est_sum[EST_W-1:0];
    end
  end

  // restoring division, one quotient bit a cycle
  assign div_ge   = rem >= {1'b0, dsum};
  assign div_diff = div_ge ? (rem - {1'b0, dsum}) : rem;
  assign gain_q   = (dsum == '0) ? '0 : quot;

  assign status.div_last = (cnt == CNT_W'(FRAC_BITS));

  always_ff @(posedge clk) begin
    if (cmd.load_state) begin
      est_value <= init_est;
      est_error <= init_err;
    end
    if (cmd.capture) begin
      innov <= $signed({1'b0, measurement, {FRAC_BITS{1'b0}}}) - $signed({1'b0, est_value});
    end
    if (cmd.mul_est || cmd.mul_err) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.upd_est) begin
      est_value <= est_sat;
    end
    if (cmd.div_start) begin
      rem  <= {2'b00, est_error};
      dsum <= {1'b0, est_error} + {1'b0, meas_err};
      quot <= '0;
      cnt  <= '0;
    end else if (cmd.div_step) begin
      rem  <= {div_diff[REM_W-2:0], 1'b0};
      quot <= {quot[GAIN_W-2:0], div_ge};
      cnt  <= cnt + 1'b1;
    end
    if (cmd.set_gain || cmd.mul_err) begin
      gain_reg <= gain_q;
    end
    if (cmd.upd_err) begin
      est_error <= prod[FRAC_BITS+ERR_W-1:FRAC_BITS];
    end
    if (cmd.out_load) begin
      res_estimate <= est_value;
      res_error    <= est_error;
      res_gain     <= gain_reg;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scalar_kalman_filter_top.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top
// Fixed-point scalar kalman filter without process noise, one result per
// raw converter sample.
// ----------------------------------------------------------------------------
// usage
//   sample: request channel with one unsigned raw sample per request
//   result: request channel with updated estimate (q12.16), estimate error
//     (q16.16) and the newly formed gain (q1.16, one is 1 << FRAC_BITS)
//   cfg_*: write-only port; index 0 initial estimate, 1 initial error,
//     2 measurement error; a write to any of them reloads the filter state
// sequence
//   one sample at a time: a new one is taken only once the last result has
//     gone to the output register; a FRAC_BITS + 1 step restoring divider forms the gain
//   per sample: estimate update with the held gain, new gain, error update, output load
// reset
//   configuration returns to 1024.0 / 2.0 / 2.0, then a reload forms the
//     starting gain; no sample is taken meanwhile
// stall
//   a finished result sits in the output register; the next sample is still
//     taken and worked on, and only its final write-back waits for the slot
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter_top #(
  parameter int SAMPLE_BITS = 12,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [((SAMPLE_BITS+FRAC_BITS) > skf_pkg::ERR_W ?
                      (SAMPLE_BITS+FRAC_BITS) : skf_pkg::ERR_W)-1:0] cfg_data,
  skf_sample_if.sink                         sample,
  skf_result_if.source                       result
);

  // command and status bundles between sequencer and datapath
  skf_pkg::skf_cmd_t    cmd;
  skf_pkg::skf_status_t status;

  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // state, multiplier, divider and output register
  skf_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .measurement  (sample.measurement),
    .cmd          (cmd),
    .status       (status),
    .res_estimate (result.estimate),
    .res_error    (result.error_estimate),
    .res_gain     (result.gain)
  );

endmodule

`default_nettype wire
